// ----- rtl/ggef_pkg.sv -----
// shared types and constants for the green-gauss edge flux block
package ggef_pkg;

  localparam int COORD_W     = 32;
  localparam int NORM_W      = 16;
  localparam int NORMAL_FRAC = 14;
  localparam int ACC_W       = 56;
  localparam int OUT_W       = 48;
  localparam int AXES        = 3;

  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] dmag;
    logic [COORD_W-1:0]           amag;
    logic                         avg_neg;
    logic [AXES-1:0][NORM_W-1:0]  nmag;
    logic [AXES-1:0]              nneg;
    logic                         last;
  } ggef_task_t;

endpackage

// ----- rtl/ggef_ifs.sv -----
// edge input and flux output channel interfaces
interface ggef_edge_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic signed [31:0] own_value;
  logic signed [31:0] neighbor_value;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               last_edge;

  modport source(output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 own_value, neighbor_value, normal_x, normal_y, normal_z, last_edge,
                 input ready);
  modport sink(input valid, start_x, start_y, start_z, end_x, end_y, end_z,
               own_value, neighbor_value, normal_x, normal_y, normal_z, last_edge,
               output ready);
endinterface

interface ggef_grad_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] grad_x;
  logic signed [47:0] grad_y;
  logic signed [47:0] grad_z;

  modport source(output valid, grad_x, grad_y, grad_z, input ready);
  modport sink(input valid, grad_x, grad_y, grad_z, output ready);
endinterface

// ----- rtl/ggef_front.sv -----
// front stage: takes an edge item and forms magnitudes, signs and the value average
module ggef_front
  import ggef_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ggef_edge_if.sink  tri_edge,
  output logic       task_valid,
  input  logic       task_ready,
  output ggef_task_t task_data
);

  logic       held;
  ggef_task_t task_q;
  ggef_task_t task_next;
  logic signed [COORD_W:0] d [AXES];
  logic signed [COORD_W:0] vsum;
  logic [COORD_W-1:0]      avg;

  assign tri_edge.ready = !held || task_ready;
  assign task_valid     = held;
  assign task_data      = task_q;

  always_comb begin
    d[0] = {tri_edge.end_x[31], tri_edge.end_x} - {tri_edge.start_x[31], tri_edge.start_x};
    d[1] = {tri_edge.end_y[31], tri_edge.end_y} - {tri_edge.start_y[31], tri_edge.start_y};
    d[2] = {tri_edge.end_z[31], tri_edge.end_z} - {tri_edge.start_z[31], tri_edge.start_z};
    vsum = {tri_edge.own_value[31], tri_edge.own_value}
         + {tri_edge.neighbor_value[31], tri_edge.neighbor_value};
    avg  = vsum[COORD_W:1];
    for (int i = 0; i < AXES; i++) begin
      task_next.dmag[i] = d[i][COORD_W] ? COORD_W'(-d[i]) : d[i][COORD_W-1:0];
    end
    task_next.amag    = avg[COORD_W-1] ? -avg : avg;
    task_next.avg_neg = avg[COORD_W-1];
    task_next.nmag[0] = tri_edge.normal_x[15] ? -tri_edge.normal_x : tri_edge.normal_x;
    task_next.nmag[1] = tri_edge.normal_y[15] ? -tri_edge.normal_y : tri_edge.normal_y;
    task_next.nmag[2] = tri_edge.normal_z[15] ? -tri_edge.normal_z : tri_edge.normal_z;
    task_next.nneg    = {tri_edge.normal_z[15], tri_edge.normal_y[15], tri_edge.normal_x[15]};
    task_next.last    = tri_edge.last_edge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (tri_edge.valid && tri_edge.ready) begin
      held <= 1'b1;
    end else if (task_ready) begin
      held <= 1'b0;
    end
    if (tri_edge.valid && tri_edge.ready) begin
      task_q <= task_next;
    end
  end

endmodule

// ----- rtl/ggef_queue.sv -----
// two-entry queue between front and back
module ggef_queue
  import ggef_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  ggef_task_t wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output ggef_task_t rd_data
);

  ggef_task_t  slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- rtl/ggef_back.sv -----
// back sequencer: edge length by bitwise square root, flux terms, sums and result register
module ggef_back
  import ggef_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        task_valid,
  output logic        task_ready,
  input  ggef_task_t  task_data,
  ggef_grad_if.source flux
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic [2:0]                  state;
  ggef_task_t                  work;
  logic [1:0]                  k;
  logic [63:0]                 sq;
  logic [63:0]                 rem;
  logic [63:0]                 res;
  logic [63:0]                 bitm;
  logic [COORD_W:0]            t1;
  logic [63:0]                 p2;
  logic [AXES-1:0][ACC_W-1:0]  acc;
  logic                        out_valid;
  logic [OUT_W-1:0]            out_g [AXES];

  logic [63:0]       sq_prod;
  logic [64:0]       sq_sum;
  logic [63:0]       trial;
  logic [47:0]       mul1;
  logic [63:0]       mul2;
  logic [63:0]       shifted;
  logic [ACC_W-1:0]  tmag;
  logic [ACC_W-1:0]  term;
  logic [ACC_W:0]    asum;
  logic [ACC_W-1:0]  acc_next;
  logic [OUT_W-1:0]  clamped [AXES];

  assign task_ready = (state == S_IDLE);
  assign flux.valid  = out_valid;
  assign flux.grad_x = out_g[0];
  assign flux.grad_y = out_g[1];
  assign flux.grad_z = out_g[2];

  always_comb begin
    sq_prod  = 64'(work.dmag[k]) * 64'(work.dmag[k]);
    sq_sum   = {1'b0, sq} + {1'b0, sq_prod};
    trial    = res + bitm;
    mul1     = 48'(work.amag) * 48'(work.nmag[k]);
    mul2     = 64'(t1[COORD_W-1:0]) * 64'(res[31:0]);
    shifted  = p2 >> FRAC_BITS;
    tmag     = (|shifted[63:ACC_W-1]) ? ACC_MAX : shifted[ACC_W-1:0];
    term     = (work.avg_neg != work.nneg[k]) ? -tmag : tmag;
    asum     = {acc[k][ACC_W-1], acc[k]} + {term[ACC_W-1], term};
    if (asum[ACC_W] != asum[ACC_W-1]) begin
      acc_next = asum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = asum[ACC_W-1:0];
    end
    for (int i = 0; i < AXES; i++) begin
      if (!acc[i][ACC_W-1] && (|acc[i][ACC_W-2:OUT_W-1])) begin
        clamped[i] = OUT_MAX;
      end else if (acc[i][ACC_W-1] && !(&acc[i][ACC_W-2:OUT_W-1])) begin
        clamped[i] = OUT_MIN;
      end else begin
        clamped[i] = acc[i][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      acc       <= '0;
      k         <= 2'd0;
    end else begin
      if (out_valid && flux.ready && (state != S_EMIT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (task_valid) begin
            work  <= task_data;
            sq    <= '0;
            k     <= 2'd0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq <= sq_sum[64] ? '1 : sq_sum[63:0];
          if (k == 2'd2) begin
            rem   <= sq_sum[64] ? '1 : sq_sum[63:0];
            res   <= '0;
            bitm  <= 64'd1 << 62;
            state <= S_ROOT;
          end else begin
            k <= k + 2'd1;
          end
        end
        S_ROOT: begin
          if (rem >= trial) begin
            rem <= rem - trial;
            res <= (res >> 1) + bitm;
          end else begin
            res <= res >> 1;
          end
          bitm <= bitm >> 2;
          if (bitm[0]) begin
            k     <= 2'd0;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          t1    <= mul1[NORMAL_FRAC+COORD_W:NORMAL_FRAC];
          state <= S_MUL2;
        end
        S_MUL2: begin
          p2    <= mul2 + (t1[COORD_W] ? {res[31:0], 32'd0} : 64'd0);
          state <= S_ACC;
        end
        S_ACC: begin
          acc[k] <= acc_next;
          if (k == 2'd2) begin
            state <= work.last ? S_EMIT : S_IDLE;
          end else begin
            k     <= k + 2'd1;
            state <= S_MUL1;
          end
        end
        S_EMIT: begin
          if (!out_valid || flux.ready) begin
            for (int i = 0; i < AXES; i++) out_g[i] <= clamped[i];
            out_valid <= 1'b1;
            acc       <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/green_gauss_edge_flux_gradient.sv -----
// top level of the green-gauss edge flux accumulator
//
//   channel   dir  payload
//   tri_edge  in   start/end points, own/neighbor values, normal, last_edge
//   flux      out  grad_x, grad_y, grad_z
//
// in the back sequencer one edge goes through 1 take step, 3 squaring steps,
// 32 root steps on the shared compare/subtract, 3 x 3 multiply/accumulate steps
// the last edge of a cell adds 1 step to load the output register
// the front register and the two-entry queue take new edges while the back works
// a result waits in the output register; the back stalls only on a second result
// synchronous reset clears the sums, the queue and all valid flags
module green_gauss_edge_flux_gradient
  import ggef_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  ggef_edge_if.sink   tri_edge,
  ggef_grad_if.source flux
);

  logic       f_valid;
  logic       f_ready;
  ggef_task_t f_data;
  logic       b_valid;
  logic       b_ready;
  ggef_task_t b_data;

  ggef_front u_front (
    .clk        (clk),
    .rst        (rst),
    .tri_edge   (tri_edge),
    .task_valid (f_valid),
    .task_ready (f_ready),
    .task_data  (f_data)
  );

  ggef_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  ggef_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .task_valid (b_valid),
    .task_ready (b_ready),
    .task_data  (b_data),
    .flux       (flux)
  );

endmodule
